### design/assert_macros.svh
// assertion macros shared by the design files
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

### design/ysc_pkg.sv
// types, constants and helper functions of the seconds-of-year date clock
// no dependencies
package ysc_pkg;

  localparam int unsigned COUNT_W = 25;
  localparam int unsigned MONTHS  = 12;

  localparam logic [COUNT_W-1:0] SECS_PER_YEAR = 25'd31536000;
  localparam logic [COUNT_W-1:0] RESET_COUNT   = 25'd29116800;
  localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;

  // request kinds
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // blanking codes
  localparam logic [2:0] BLANK_NONE   = 3'd0;
  localparam logic [2:0] BLANK_SECOND = 3'd5;

  localparam logic [3:0] MONTH_ERROR = 4'd12;

  // reciprocal of 60, exact for any 25-bit dividend
  localparam logic [25:0] RECIP_60 = 26'd35791395;
  // reciprocal of 24, exact for any 14-bit dividend
  localparam logic [14:0] RECIP_24 = 15'd21846;

  // zero-based day of year on which each month starts
  localparam logic [8:0] MONTH_START [MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [19:0] quot;
    logic [5:0]  rem;
  } div60_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  typedef struct packed {
    logic [3:0] month_code;
    logic [1:0] day_tens;
    logic [3:0] day_ones;
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
    logic [2:0] blanked_field;
  } result_t;

  // quotient and remainder by 60 through a reciprocal multiply
  function automatic div60_t div60(input logic [COUNT_W-1:0] n);
    logic [50:0] prod;
    logic [25:0] back;
    div60_t      d;
    prod   = n * RECIP_60;
    d.quot = prod[50:31];
    back   = {d.quot, 6'd0} - {4'd0, d.quot, 2'd0};
    d.rem  = 6'(n - back[COUNT_W-1:0]);
    return d;
  endfunction

  // two decimal digits of a value below 60
  function automatic digits_t split_digits(input logic [5:0] value);
    digits_t d;
    d.tens = 3'd0;
    for (int t = 1; t <= 5; t++) begin
      if (value >= 6'(10 * t)) begin
        d.tens = 3'(t);
      end
    end
    d.ones = 4'(value - 6'(d.tens) * 6'd10);
    return d;
  endfunction

endpackage

### design/ysc_item_if.sv
// request channel of the date clock: tick or load, plus blanking choice
// no dependencies
interface ysc_item_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [24:0] load_seconds;
  logic [2:0]  blank_select;

  modport source (output valid, mode, load_seconds, blank_select, input ready);
  modport sink   (input valid, mode, load_seconds, blank_select, output ready);
endinterface

### design/ysc_result_if.sv
// result channel of the date clock: month code and decimal digits
// no dependencies
interface ysc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] month_code;
  logic [1:0] day_tens;
  logic [3:0] day_ones;
  logic [1:0] hour_tens;
  logic [3:0] hour_ones;
  logic [2:0] minute_tens;
  logic [3:0] minute_ones;
  logic [2:0] second_tens;
  logic [3:0] second_ones;
  logic [2:0] blanked_field;

  modport source (output valid, month_code, day_tens, day_ones, hour_tens, hour_ones,
                  minute_tens, minute_ones, second_tens, second_ones, blanked_field,
                  input ready);
  modport sink   (input valid, month_code, day_tens, day_ones, hour_tens, hour_ones,
                  minute_tens, minute_ones, second_tens, second_ones, blanked_field,
                  output ready);
endinterface

### design/ysc_date_decode.sv
// month lookup and decimal digit split of day, hour, minute and second
// depends on ysc_pkg
module ysc_date_decode (
  input  logic [8:0]       day_index,
  input  logic [4:0]       hour,
  input  logic [5:0]       minute,
  input  logic [5:0]       second,
  input  logic [2:0]       blank_select,
  output ysc_pkg::result_t result
);
  import ysc_pkg::*;

  logic [3:0] month;
  logic [4:0] day_of_month;
  logic [8:0] day_offset;
  digits_t    day_dg;
  digits_t    hour_dg;
  digits_t    minute_dg;
  digits_t    second_dg;

  always_comb begin
    month = 4'd0;
    for (int k = 1; k < MONTHS; k++) begin
      if (day_index >= MONTH_START[k]) begin
        month = 4'(k);
      end
    end
    day_offset   = day_index - MONTH_START[month] + 9'd1;
    day_of_month = day_offset[4:0];
    // past the last day of the year
    if (day_index >= DAYS_PER_YEAR) begin
      month        = MONTH_ERROR;
      day_of_month = 5'd0;
    end
  end

  always_comb begin
    day_dg    = split_digits({1'b0, day_of_month});
    hour_dg   = split_digits({1'b0, hour});
    minute_dg = split_digits(minute);
    second_dg = split_digits(second);
  end

  always_comb begin
    result.month_code    = month;
    result.day_tens      = day_dg.tens[1:0];
    result.day_ones      = day_dg.ones;
    result.hour_tens     = hour_dg.tens[1:0];
    result.hour_ones     = hour_dg.ones;
    result.minute_tens   = minute_dg.tens;
    result.minute_ones   = minute_dg.ones;
    result.second_tens   = second_dg.tens;
    result.second_ones   = second_dg.ones;
    result.blanked_field = (blank_select <= BLANK_SECOND) ? blank_select : BLANK_NONE;
  end

endmodule

### design/year_seconds_clock_to_date_digits.sv
// Seconds-of-year clock that decodes its count into month, day and time digits.
// A request is either a one-second tick or a load of a new count; each request
// gives exactly one result. The count resets to 29116800. A tick wraps the
// count to zero once it has reached 31536000 (that value is shown for one
// tick), any 25-bit load is kept as given. Each request moves through the
// stage registers and then the result register; a new request is taken every
// cycle, back to back, as long as the result side keeps up; a stall on the
// result side holds the whole pipe. The decode path holds two reciprocal
// multiplies by 60 and one by 24, each in a stage of its own, then the month
// lookup and digit split ahead of the result register. A day beyond 365
// shows month code 12 with day digits zero. Blank select codes 6 and 7 are
// echoed as zero. No clearing pass or start-up delay after reset.
// depends on ysc_pkg, ysc_item_if, ysc_result_if, ysc_date_decode
`include "assert_macros.svh"

module year_seconds_clock_to_date_digits (
  input logic          clk,
  input logic          rst,
  ysc_item_if.sink     item,
  ysc_result_if.source result
);
  import ysc_pkg::*;

  // whole pipe moves when the result register is free or being emptied
  logic advance;
  logic accept;

  logic [COUNT_W-1:0] seconds_count;
  logic [COUNT_W-1:0] seconds_count_next;

  // stage 1: updated count
  logic               s1_valid;
  logic [COUNT_W-1:0] s1_count;
  logic [2:0]         s1_sel;
  // stage 2: whole minutes and seconds
  logic               s2_valid;
  logic [19:0]        s2_minutes;
  logic [5:0]         s2_second;
  logic [2:0]         s2_sel;
  // stage 3: whole hours, minute of hour
  logic               s3_valid;
  logic [13:0]        s3_hours;
  logic [5:0]         s3_minute;
  logic [5:0]         s3_second;
  logic [2:0]         s3_sel;
  // stage 4: day of year, hour of day
  logic               s4_valid;
  logic [8:0]         s4_day_index;
  logic [4:0]         s4_hour;
  logic [5:0]         s4_minute;
  logic [5:0]         s4_second;
  logic [2:0]         s4_sel;
  // result register
  logic               out_valid;
  result_t            out_data;

  div60_t  sec_split;
  div60_t  min_split;
  logic [28:0] hour_prod;
  logic [8:0]  day_quot;
  logic [13:0] day_back;
  result_t     decoded;

  assign advance = !out_valid || result.ready;
  assign accept  = item.valid && advance;
  assign item.ready = advance;

  // count update on each request
  always_comb begin
    if (item.mode == MODE_LOAD) begin
      seconds_count_next = item.load_seconds;
    end else if (seconds_count >= SECS_PER_YEAR) begin
      seconds_count_next = '0;
    end else begin
      seconds_count_next = seconds_count + 25'd1;
    end
  end

  // divide chain, one reciprocal multiply per stage
  always_comb begin
    sec_split = div60(s1_count);
    min_split = div60({5'd0, s2_minutes});
    hour_prod = s3_hours * RECIP_24;
    day_quot  = hour_prod[27:19];
    // whole days times 24, as 16 plus 8
    day_back  = {1'd0, day_quot, 4'd0} + {2'd0, day_quot, 3'd0};
  end

  ysc_date_decode u_decode (
    .day_index    (s4_day_index),
    .hour         (s4_hour),
    .minute       (s4_minute),
    .second       (s4_second),
    .blank_select (s4_sel),
    .result       (decoded)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count <= RESET_COUNT;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        seconds_count <= seconds_count_next;
      end
      if (advance) begin
        s1_valid  <= item.valid;
        s2_valid  <= s1_valid;
        s3_valid  <= s2_valid;
        s4_valid  <= s3_valid;
        out_valid <= s4_valid;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_count     <= seconds_count_next;
      s1_sel       <= item.blank_select;
      s2_minutes   <= sec_split.quot;
      s2_second    <= sec_split.rem;
      s2_sel       <= s1_sel;
      s3_hours     <= min_split.quot[13:0];
      s3_minute    <= min_split.rem;
      s3_second    <= s2_second;
      s3_sel       <= s2_sel;
      s4_day_index <= day_quot;
      s4_hour      <= 5'(s3_hours - day_back);
      s4_minute    <= s3_minute;
      s4_second    <= s3_second;
      s4_sel       <= s3_sel;
      out_data     <= decoded;
    end
  end

  assign result.valid         = out_valid;
  assign result.month_code    = out_data.month_code;
  assign result.day_tens      = out_data.day_tens;
  assign result.day_ones      = out_data.day_ones;
  assign result.hour_tens     = out_data.hour_tens;
  assign result.hour_ones     = out_data.hour_ones;
  assign result.minute_tens   = out_data.minute_tens;
  assign result.minute_ones   = out_data.minute_ones;
  assign result.second_tens   = out_data.second_tens;
  assign result.second_ones   = out_data.second_ones;
  assign result.blanked_field = out_data.blanked_field;

  `ASSERT_NEXT(a_tick_increments, clk, rst,
    accept && item.mode == MODE_TICK && seconds_count < SECS_PER_YEAR,
    seconds_count == $past(seconds_count) + 25'd1, "tick did not increment count")
  `ASSERT_NEXT(a_tick_wraps, clk, rst,
    accept && item.mode == MODE_TICK && seconds_count >= SECS_PER_YEAR,
    seconds_count == '0, "tick at end of year did not wrap")
  `ASSERT_NEXT(a_load_taken, clk, rst, accept && item.mode == MODE_LOAD,
    seconds_count == $past(item.load_seconds), "load value not stored")
  `ASSERT_IMPLIES(a_time_in_range, clk, rst, s4_valid,
    s4_second < 6'd60 && s4_minute < 6'd60 && s4_hour < 5'd24, "time field out of range")
  `ASSERT_NEXT(a_stall_holds_pipe, clk, rst, !advance,
    $stable(s4_valid) && $stable(s4_day_index) && $stable(out_data), "pipe moved while stalled")

endmodule

### bench/ysc_date_checker.sv
`timescale 1ns / 100ps
// watcher of the date clock channels: mirrors the seconds count and checks every result
// depends on ysc_pkg, ysc_item_if and ysc_result_if
module ysc_date_checker (
  input  logic  clk,
  input  logic  rst,
  ysc_item_if   item,
  ysc_result_if result,
  output int    fail_count,
  output int    pending
);
  import ysc_pkg::*;

  localparam int unsigned SECS_IN_DAY  = 86400;
  localparam int unsigned SECS_IN_HOUR = 3600;
  localparam int unsigned DAYS_IN_YEAR = 365;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic [COUNT_W-1:0] clock_count;
  result_t            expected_dates [$];
  int                 errors;

  assign fail_count = errors;
  assign pending    = expected_dates.size();

  // calendar and clock digits of a seconds-of-year count
  function automatic result_t decode_date(input logic [COUNT_W-1:0] count,
                                          input logic [2:0] sel);
    result_t     r;
    int unsigned secs;
    int unsigned day_idx;
    int unsigned dom;
    int unsigned hh;
    int unsigned mm;
    int unsigned ss;
    int          k;
    bit          found;
    secs    = count;
    day_idx = secs / SECS_IN_DAY;
    r       = '0;
    if (day_idx >= DAYS_IN_YEAR) begin
      r.month_code = MONTH_ERROR;
      dom          = 0;
    end else begin
      found = 1'b0;
      for (k = 0; k < 12; k++) begin
        if (!found) begin
          if (day_idx < MONTH_DAYS[k]) begin
            r.month_code = 4'(k);
            found        = 1'b1;
          end else begin
            day_idx -= MONTH_DAYS[k];
          end
        end
      end
      dom = day_idx + 1;
    end
    hh = (secs / SECS_IN_HOUR) % 24;
    mm = (secs / 60) % 60;
    ss = secs % 60;
    r.day_tens      = 2'(dom / 10);
    r.day_ones      = 4'(dom % 10);
    r.hour_tens     = 2'(hh / 10);
    r.hour_ones     = 4'(hh % 10);
    r.minute_tens   = 3'(mm / 10);
    r.minute_ones   = 4'(mm % 10);
    r.second_tens   = 3'(ss / 10);
    r.second_ones   = 4'(ss % 10);
    r.blanked_field = (sel <= BLANK_SECOND) ? sel : BLANK_NONE;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clock_count <= RESET_COUNT;
      errors      <= 0;
      expected_dates.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result with nothing expected, actual month %0d", $time,
                   result.month_code);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          check_field("month_code", want.month_code, result.month_code);
          check_field("day_tens", want.day_tens, result.day_tens);
          check_field("day_ones", want.day_ones, result.day_ones);
          check_field("hour_tens", want.hour_tens, result.hour_tens);
          check_field("hour_ones", want.hour_ones, result.hour_ones);
          check_field("minute_tens", want.minute_tens, result.minute_tens);
          check_field("minute_ones", want.minute_ones, result.minute_ones);
          check_field("second_tens", want.second_tens, result.second_tens);
          check_field("second_ones", want.second_ones, result.second_ones);
          check_field("blanked_field", want.blanked_field, result.blanked_field);
        end
      end
      if (item.valid && item.ready) begin
        logic [COUNT_W-1:0] next_count;
        if (item.mode == MODE_LOAD) begin
          next_count = item.load_seconds;
        end else if (clock_count >= SECS_PER_YEAR) begin
          next_count = '0;
        end else begin
          next_count = clock_count + 1'b1;
        end
        clock_count <= next_count;
        expected_dates.push_back(decode_date(next_count, item.blank_select));
      end
    end
  end

endmodule

### bench/tb_year_seconds_clock_to_date_digits.sv
`timescale 1ns / 100ps
// top of the date clock bench: clock, reset, requests and result-side stalls
// depends on ysc_pkg, both channel interfaces, the block and ysc_date_checker
module tb_year_seconds_clock_to_date_digits;
  import ysc_pkg::*;

  localparam int unsigned DAY_SECS    = 86400;
  localparam int unsigned HOUR_SECS   = 3600;
  localparam int unsigned ITEM_TARGET = 1050;
  // last stretch of requests runs with no idling on either side
  localparam int unsigned CALM_TAIL   = 150;
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned COUNT_TOP   = 33554431;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent;
  int   cycles;
  bit   quiet;

  ysc_item_if   item_ch ();
  ysc_result_if result_ch ();

  year_seconds_clock_to_date_digits dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // predicts and compares; stimulus side only reads the counts back
  ysc_date_checker date_chk (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one request: optional idle burst first, then hold valid until it is taken
  task automatic send_request(input logic m, input logic [COUNT_W-1:0] secs,
                              input logic [2:0] sel);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= m;
    item_ch.load_seconds <= secs;
    item_ch.blank_select <= sel;
    do @(posedge clk); while (!item_ch.ready);
    sent++;
  endtask

  // tick carries junk in the load field, which the block must ignore
  task automatic tick(input logic [2:0] sel);
    send_request(MODE_TICK, COUNT_W'($urandom), sel);
  endtask

  task automatic load(input int unsigned secs, input logic [2:0] sel);
    send_request(MODE_LOAD, COUNT_W'(secs), sel);
  endtask

  // result side: random stall bursts until the calm tail
  initial begin
    result_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned month;
    int          target;
    int unsigned run;
    sent   = 0;
    quiet  = 1'b0;
    rst                  <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.mode         <= MODE_TICK;
    item_ch.load_seconds <= '0;
    item_ch.blank_select <= BLANK_NONE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part
    tick(3'd0);                              // first tick out of the reset count
    load(0, 3'd1);                           // start of year
    tick(3'd2);
    load(SECS_PER_YEAR - 1, 3'd3);           // last second of december
    tick(3'd4);                              // reaches the year length: error month
    tick(3'd5);                              // held value wraps to zero
    load(SECS_PER_YEAR, 3'd6);               // error month loaded directly, blank code 6
    load(COUNT_TOP, 3'd7);                   // all ones count, blank code 7
    tick(3'd0);                              // wrap from above the range
    load(31 * DAY_SECS - 1, 3'd1);           // end of january
    tick(3'd2);
    load(59 * DAY_SECS - 1, 3'd3);           // end of february, no leap day
    tick(3'd4);
    load(25'h0AAAAAA, 3'd5);                 // alternating bit patterns
    load(25'h1555555, 3'd2);
    load(364 * DAY_SECS, 3'd0);              // first second of the last day
    load(9 * DAY_SECS + 19 * HOUR_SECS + 9 * 60 + 9, 3'd1);
    load(SECS_PER_YEAR + 1, 3'd4);           // just beyond the range
    tick(3'd3);
    tick(3'd5);
    load(334 * DAY_SECS - 1, 3'd6);          // end of november
    tick(3'd7);

    // random part: a load followed by a run of ticks, with odd noise loads
    while (sent < ITEM_TARGET) begin
      if (sent >= ITEM_TARGET - CALM_TAIL) begin
        quiet = 1'b1;
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          target = $urandom_range(0, SECS_PER_YEAR);
        end
        3, 4: begin
          // around a month boundary
          month  = $urandom_range(0, MONTHS - 1);
          target = MONTH_START[month] * DAY_SECS + $urandom_range(0, 10) - 5;
        end
        5, 6: begin
          // around the end of the year, so ticks run through the wrap
          target = SECS_PER_YEAR - $urandom_range(0, 8);
        end
        7: begin
          // beyond the year, anywhere up to the full count width
          target = $urandom_range(SECS_PER_YEAR + 1, COUNT_TOP);
        end
        default: begin
          // near a day, hour or minute rollover
          target = $urandom_range(0, 364) * DAY_SECS + $urandom_range(0, 23) * HOUR_SECS
                   + $urandom_range(0, 59) * 60 + $urandom_range(0, 10) - 5;
        end
      endcase
      if (target < 0) begin
        target = 0;
      end
      load(target, 3'($urandom));
      run = $urandom_range(0, 12);
      repeat (run) tick(3'($urandom));
    end

    item_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ysc_pkg.sv
design/ysc_item_if.sv
design/ysc_result_if.sv
design/ysc_date_decode.sv
design/year_seconds_clock_to_date_digits.sv
bench/ysc_date_checker.sv
bench/tb_year_seconds_clock_to_date_digits.sv
